[hdl/mse_pkg.sv]
// Shared types and constants for the metasprite slot expander.
package mse_pkg;

    localparam int MAX_SLOTS_DEFAULT = 40;
    localparam int SLOT_W            = 6;
    localparam int COORD_W           = 8;
    localparam int TILE_W            = 8;
    localparam int ATTR_W            = 8;
    localparam int DIM_W             = 4;

    localparam logic [ATTR_W-1:0]  MIRROR_BIT = 8'h20;
    localparam logic [COORD_W-1:0] COL_STEP   = 8'd8;
    localparam logic [COORD_W-1:0] ROW_STEP   = 8'd16;

    typedef enum logic [1:0] {
        MODE_FRAME_START = 2'd0,
        MODE_HEADER      = 2'd1,
        MODE_CELL        = 2'd2,
        MODE_FRAME_END   = 2'd3
    } t_mode;

    typedef struct packed {
        logic frame_start;
        logic header;
        logic cell_step;
        logic fill_step;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic fill_last;
        logic out_free;
    } t_status;

endpackage

[hdl/mse_ctrl.sv]
// Sequencer for input transfers and the frame-end blank fill.
module mse_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [1:0]      i_mode,
    input  mse_pkg::t_status i_status,
    output logic            o_ready,
    output mse_pkg::t_cmd   o_cmd
);
    import mse_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_FILL
    } t_state;

    t_state r_state;
    t_state n_state;
    t_mode  w_mode;
    logic   w_accept;

    assign w_mode   = t_mode'(i_mode);
    assign o_ready  = (r_state == S_IDLE) && i_status.out_free;
    assign w_accept = i_valid && o_ready;

    always_comb begin
        o_cmd             = '0;
        o_cmd.frame_start = w_accept && (w_mode == MODE_FRAME_START);
        o_cmd.header      = w_accept && (w_mode == MODE_HEADER) && !i_status.full;
        o_cmd.cell_step   = w_accept && (w_mode == MODE_CELL) && !i_status.full;
        o_cmd.fill_step   = (r_state == S_FILL) && i_status.out_free;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && (w_mode == MODE_FRAME_END) && !i_status.full) begin
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                if (i_status.out_free && i_status.fill_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[hdl/mse_datapath.sv]
// Sprite cursor, slot counter, header latch and output register.
module mse_datapath #(
    parameter int MAX_SLOTS = mse_pkg::MAX_SLOTS_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mse_pkg::t_cmd                i_cmd,
    output mse_pkg::t_status             o_status,
    input  logic                         i_cfg_valid,
    input  logic [mse_pkg::TILE_W-1:0]   i_cfg_data,
    input  logic [mse_pkg::COORD_W-1:0]  i_sprite_x,
    input  logic [mse_pkg::COORD_W-1:0]  i_sprite_y,
    input  logic [mse_pkg::DIM_W-1:0]    i_width_tiles,
    input  logic [mse_pkg::DIM_W-1:0]    i_height_tiles,
    input  logic                         i_visible,
    input  logic                         i_mirrored,
    input  logic [mse_pkg::ATTR_W-1:0]   i_extra_attr,
    input  logic [mse_pkg::TILE_W-1:0]   i_tile_index,
    input  logic [mse_pkg::ATTR_W-1:0]   i_palette_attr,
    input  logic                         i_ready,
    output logic                         o_valid,
    output logic [mse_pkg::SLOT_W-1:0]   o_slot,
    output logic                         o_tile_only,
    output logic [mse_pkg::TILE_W-1:0]   o_tile_out,
    output logic [mse_pkg::ATTR_W-1:0]   o_attr_out,
    output logic [mse_pkg::COORD_W-1:0]  o_screen_x,
    output logic [mse_pkg::COORD_W-1:0]  o_screen_y,
    output logic                         o_last
);
    import mse_pkg::*;

    localparam int CNT_W = $clog2(MAX_SLOTS + 1);
    localparam logic [CNT_W-1:0] LAST_SLOT = CNT_W'(MAX_SLOTS - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(MAX_SLOTS);

    logic [TILE_W-1:0]  r_empty_tile;
    logic [CNT_W-1:0]   r_slot_count;
    logic [DIM_W-1:0]   r_cell_column;
    logic [DIM_W-1:0]   r_cell_row;
    logic [COORD_W-1:0] r_pen_x;
    logic [COORD_W-1:0] r_pen_y;
    logic [COORD_W-1:0] r_row_start_x;
    logic [DIM_W-1:0]   r_held_width;
    logic [DIM_W-1:0]   r_held_height;
    logic               r_held_visible;
    logic               r_held_mirrored;
    logic [ATTR_W-1:0]  r_held_attr;
    logic               r_out_valid;

    logic [COORD_W-1:0] w_header_x;
    logic               w_cell_live;
    logic               w_cell_emit;
    logic [DIM_W-1:0]   w_col_next;
    logic               w_row_end;

    assign o_status.full      = (r_slot_count >= FULL_CNT);
    assign o_status.fill_last = (r_slot_count == LAST_SLOT);
    assign o_status.out_free  = !r_out_valid || i_ready;
    assign o_valid            = r_out_valid;

    assign w_header_x  = i_mirrored
                       ? (i_sprite_x + COORD_W'({i_width_tiles, 3'b000}) - COL_STEP)
                       : i_sprite_x;
    assign w_cell_live = r_held_visible && (r_held_width != '0)
                       && (r_cell_row < r_held_height);
    assign w_cell_emit = i_cmd.cell_step && w_cell_live && (i_tile_index != r_empty_tile);
    assign w_col_next  = r_cell_column + DIM_W'(1);
    assign w_row_end   = (w_col_next >= r_held_width);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_empty_tile    <= '0;
            r_slot_count    <= '0;
            r_cell_column   <= '0;
            r_cell_row      <= '0;
            r_pen_x         <= '0;
            r_pen_y         <= '0;
            r_row_start_x   <= '0;
            r_held_width    <= '0;
            r_held_height   <= '0;
            r_held_visible  <= 1'b0;
            r_held_mirrored <= 1'b0;
            r_held_attr     <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_empty_tile <= i_cfg_data;
            end
            r_out_valid <= w_cell_emit || i_cmd.fill_step || (r_out_valid && !i_ready);
            if (i_cmd.frame_start) begin
                r_slot_count   <= '0;
                r_cell_column  <= '0;
                r_cell_row     <= '0;
                r_held_visible <= 1'b0;
            end
            if (i_cmd.header) begin
                r_held_width    <= i_width_tiles;
                r_held_height   <= i_height_tiles;
                r_held_visible  <= i_visible;
                r_held_mirrored <= i_mirrored;
                r_held_attr     <= i_extra_attr;
                r_pen_x         <= w_header_x;
                r_row_start_x   <= w_header_x;
                r_pen_y         <= i_sprite_y;
                r_cell_column   <= '0;
                r_cell_row      <= '0;
            end
            if (i_cmd.cell_step && w_cell_live) begin
                if (w_row_end) begin
                    r_cell_column <= '0;
                    r_cell_row    <= r_cell_row + DIM_W'(1);
                    r_pen_x       <= r_row_start_x;
                    r_pen_y       <= r_pen_y + ROW_STEP;
                end else begin
                    r_cell_column <= w_col_next;
                    r_pen_x       <= r_held_mirrored ? (r_pen_x - COL_STEP)
                                                     : (r_pen_x + COL_STEP);
                end
            end
            if (w_cell_emit || i_cmd.fill_step) begin
                r_slot_count <= r_slot_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cell_emit) begin
            o_slot      <= SLOT_W'(r_slot_count);
            o_tile_only <= 1'b0;
            o_tile_out  <= i_tile_index;
            o_attr_out  <= i_palette_attr | r_held_attr
                         | (r_held_mirrored ? MIRROR_BIT : '0);
            o_screen_x  <= r_pen_x;
            o_screen_y  <= r_pen_y;
            o_last      <= 1'b1;
        end else if (i_cmd.fill_step) begin
            o_slot      <= SLOT_W'(r_slot_count);
            o_tile_only <= 1'b1;
            o_tile_out  <= r_empty_tile;
            o_attr_out  <= '0;
            o_screen_x  <= '0;
            o_screen_y  <= '0;
            o_last      <= o_status.fill_last;
        end
    end

endmodule

[hdl/metasprite_slot_expander_core.sv]
// Top level of the metasprite slot expander.
// A cell's slot write is registered and appears in the cycle after its transfer.
// Throughput: one item per cycle while the output register drains; a frame end
// takes one transfer, then emits one blank slot per cycle while the output
// register drains, up to slot MAX_SLOTS - 1, and blocks input until done.
// Reset: synchronous active low; clears counters, cursor, header, valid flag.
module metasprite_slot_expander_core #(
    parameter int MAX_SLOTS = mse_pkg::MAX_SLOTS_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [mse_pkg::TILE_W-1:0]   i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [1:0]                   i_mode,
    input  logic [mse_pkg::COORD_W-1:0]  i_sprite_x,
    input  logic [mse_pkg::COORD_W-1:0]  i_sprite_y,
    input  logic [mse_pkg::DIM_W-1:0]    i_width_tiles,
    input  logic [mse_pkg::DIM_W-1:0]    i_height_tiles,
    input  logic                         i_visible,
    input  logic                         i_mirrored,
    input  logic [mse_pkg::ATTR_W-1:0]   i_extra_attr,
    input  logic [mse_pkg::TILE_W-1:0]   i_tile_index,
    input  logic [mse_pkg::ATTR_W-1:0]   i_palette_attr,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [mse_pkg::SLOT_W-1:0]   o_slot,
    output logic                         o_tile_only,
    output logic [mse_pkg::TILE_W-1:0]   o_tile_out,
    output logic [mse_pkg::ATTR_W-1:0]   o_attr_out,
    output logic [mse_pkg::COORD_W-1:0]  o_screen_x,
    output logic [mse_pkg::COORD_W-1:0]  o_screen_y,
    output logic                         o_last
);
    import mse_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_cfg_write;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_write = i_cfg_valid && o_cfg_ready;

    mse_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_mode   (i_mode),
        .i_status (w_status),
        .o_ready  (o_ready),
        .o_cmd    (w_cmd)
    );

    mse_datapath #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_cfg_valid    (w_cfg_write),
        .i_cfg_data     (i_cfg_data),
        .i_sprite_x     (i_sprite_x),
        .i_sprite_y     (i_sprite_y),
        .i_width_tiles  (i_width_tiles),
        .i_height_tiles (i_height_tiles),
        .i_visible      (i_visible),
        .i_mirrored     (i_mirrored),
        .i_extra_attr   (i_extra_attr),
        .i_tile_index   (i_tile_index),
        .i_palette_attr (i_palette_attr),
        .i_ready        (i_ready),
        .o_valid        (o_valid),
        .o_slot         (o_slot),
        .o_tile_only    (o_tile_only),
        .o_tile_out     (o_tile_out),
        .o_attr_out     (o_attr_out),
        .o_screen_x     (o_screen_x),
        .o_screen_y     (o_screen_y),
        .o_last         (o_last)
    );

endmodule

[hdl/mse_checker.sv]
// Port-level checks for the metasprite slot expander, bound to the top level.
module mse_checker #(
    parameter int MAX_SLOTS = mse_pkg::MAX_SLOTS_DEFAULT
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_ready,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic [mse_pkg::SLOT_W-1:0]  o_slot,
    input logic                        o_tile_only,
    input logic                        o_last
);
    import mse_pkg::*;

    localparam logic [SLOT_W:0] SLOT_LIMIT = (SLOT_W + 1)'(MAX_SLOTS);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_slot) && $stable(o_last))
        else $error("stalled result changed");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({1'b0, o_slot} < SLOT_LIMIT))
        else $error("slot beyond the slot count");

    a_cell_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_tile_only |-> o_last)
        else $error("cell write without last");

    a_fill_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_tile_only && o_last |-> ({1'b0, o_slot} == SLOT_LIMIT - 1'b1))
        else $error("blank fill ended early");

    a_fill_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_tile_only && !o_last |-> !o_ready
            ##1 (o_valid && o_tile_only && (o_slot == $past(o_slot) + 1'b1)))
        else $error("blank fill skipped a slot");

endmodule

bind metasprite_slot_expander_core mse_checker #(.MAX_SLOTS(MAX_SLOTS)) u_mse_checker (.*);

[test/testbench.sv]
// Testbench for metasprite_slot_expander_core: directed table plus random frames, scoreboarded.
`timescale 1ns / 1ps

module testbench;

    import mse_pkg::*;

    localparam int SLOTS       = MAX_SLOTS_DEFAULT;
    localparam int HOLD_CYCLES = 200;
    localparam int STALL_LIMIT = 5000;
    localparam int CFG_SETTLE  = 4;

    typedef struct packed {
        t_mode       mode;
        logic [7:0]  sprite_x;
        logic [7:0]  sprite_y;
        logic [3:0]  width_tiles;
        logic [3:0]  height_tiles;
        logic        visible;
        logic        mirrored;
        logic [7:0]  extra_attr;
        logic [7:0]  tile_index;
        logic [7:0]  palette_attr;
    } t_sprite_item;

    typedef struct packed {
        logic [5:0]  slot;
        logic        tile_only;
        logic [7:0]  tile;
        logic [7:0]  attr;
        logic [7:0]  x;
        logic [7:0]  y;
        logic        is_last;
    } t_slot_write;

    typedef struct {
        t_sprite_item item;
        bit           typed;
        t_slot_write  want;
    } t_dir_row;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        cfg_valid    = 1'b0;
    logic [7:0]  cfg_data     = '0;
    logic        in_valid     = 1'b0;
    logic [1:0]  in_mode      = '0;
    logic [7:0]  in_sprite_x  = '0;
    logic [7:0]  in_sprite_y  = '0;
    logic [3:0]  in_width     = '0;
    logic [3:0]  in_height    = '0;
    logic        in_visible   = 1'b0;
    logic        in_mirrored  = 1'b0;
    logic [7:0]  in_extra     = '0;
    logic [7:0]  in_tile      = '0;
    logic [7:0]  in_palette   = '0;
    logic        rx_ready     = 1'b0;

    logic        o_cfg_ready;
    logic        o_ready;
    logic        o_valid;
    logic [5:0]  o_slot;
    logic        o_tile_only;
    logic [7:0]  o_tile_out;
    logic [7:0]  o_attr_out;
    logic [7:0]  o_screen_x;
    logic [7:0]  o_screen_y;
    logic        o_last;

    // predictor state
    logic [7:0]  blank_tile;
    logic [5:0]  used_slots;
    logic [3:0]  cur_col;
    logic [3:0]  cur_row;
    logic [7:0]  draw_x;
    logic [7:0]  draw_y;
    logic [7:0]  line_x;
    logic [3:0]  hdr_w;
    logic [3:0]  hdr_h;
    logic        hdr_vis;
    logic        hdr_mir;
    logic [7:0]  hdr_attr;

    t_slot_write expected_writes[$];
    t_dir_row    dir_rows[$];

    int          errors         = 0;
    int          items_sent     = 0;
    int          writes_checked = 0;
    int          cfg_writes     = 0;
    int          tx_idle_pct    = 0;
    int          rx_stall_pct   = 0;
    bit          hold_req       = 1'b0;
    int          quiet_cycles   = 0;

    metasprite_slot_expander_core u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (cfg_data),
        .i_valid        (in_valid),
        .o_ready        (o_ready),
        .i_mode         (in_mode),
        .i_sprite_x     (in_sprite_x),
        .i_sprite_y     (in_sprite_y),
        .i_width_tiles  (in_width),
        .i_height_tiles (in_height),
        .i_visible      (in_visible),
        .i_mirrored     (in_mirrored),
        .i_extra_attr   (in_extra),
        .i_tile_index   (in_tile),
        .i_palette_attr (in_palette),
        .o_valid        (o_valid),
        .i_ready        (rx_ready),
        .o_slot         (o_slot),
        .o_tile_only    (o_tile_only),
        .o_tile_out     (o_tile_out),
        .o_attr_out     (o_attr_out),
        .o_screen_x     (o_screen_x),
        .o_screen_y     (o_screen_y),
        .o_last         (o_last)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= 40) begin
            $display("ERROR at %0t: %s", $realtime, msg);
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want) begin
            flag_error($sformatf("%s: got %0h expected %0h", name, got, want));
        end
    endtask

    function automatic void reset_predictor();
        blank_tile = '0;
        used_slots = '0;
        cur_col    = '0;
        cur_row    = '0;
        draw_x     = '0;
        draw_y     = '0;
        line_x     = '0;
        hdr_w      = '0;
        hdr_h      = '0;
        hdr_vis    = 1'b0;
        hdr_mir    = 1'b0;
        hdr_attr   = '0;
    endfunction

    function automatic int expand_item(input t_sprite_item it);
        logic [7:0] sx;
        logic [7:0] attr;
        int         n;
        int         s;
        n = 0;
        if (it.mode == MODE_FRAME_START) begin
            used_slots = '0;
            cur_col    = '0;
            cur_row    = '0;
            hdr_vis    = 1'b0;
            return 0;
        end
        if (used_slots >= SLOTS) begin
            return 0;
        end
        case (it.mode)
            MODE_HEADER: begin
                hdr_w    = it.width_tiles;
                hdr_h    = it.height_tiles;
                hdr_vis  = it.visible;
                hdr_mir  = it.mirrored;
                hdr_attr = it.extra_attr;
                sx       = it.sprite_x;
                if (hdr_mir) begin
                    sx = sx + {1'b0, it.width_tiles, 3'b000} - COL_STEP;
                end
                draw_x  = sx;
                line_x  = sx;
                draw_y  = it.sprite_y;
                cur_col = '0;
                cur_row = '0;
            end
            MODE_CELL: begin
                if (!hdr_vis || hdr_w == 0 || cur_row >= hdr_h) begin
                    return 0;
                end
                if (it.tile_index != blank_tile) begin
                    attr = it.palette_attr | hdr_attr | (hdr_mir ? MIRROR_BIT : 8'h00);
                    expected_writes.push_back('{used_slots, 1'b0, it.tile_index, attr,
                                                draw_x, draw_y, 1'b1});
                    used_slots++;
                    n = 1;
                end
                cur_col = cur_col + 4'd1;
                if (cur_col >= hdr_w) begin
                    cur_col = '0;
                    cur_row = cur_row + 4'd1;
                    draw_x  = line_x;
                    draw_y  = draw_y + ROW_STEP;
                end else if (hdr_mir) begin
                    draw_x = draw_x - COL_STEP;
                end else begin
                    draw_x = draw_x + COL_STEP;
                end
            end
            default: begin
                for (s = used_slots; s < SLOTS; s++) begin
                    expected_writes.push_back('{s[5:0], 1'b1, blank_tile, 8'h00, 8'h00, 8'h00,
                                                (s == SLOTS - 1)});
                    n++;
                end
                used_slots = 6'(SLOTS);
            end
        endcase
        return n;
    endfunction

    function automatic t_sprite_item rand_item();
        t_sprite_item it;
        it.mode         = t_mode'($urandom_range(3));
        it.sprite_x     = 8'($urandom);
        it.sprite_y     = 8'($urandom);
        it.width_tiles  = 4'($urandom);
        it.height_tiles = 4'($urandom);
        it.visible      = 1'($urandom);
        it.mirrored     = 1'($urandom);
        it.extra_attr   = 8'($urandom);
        it.tile_index   = 8'($urandom);
        it.palette_attr = 8'($urandom);
        return it;
    endfunction

    function automatic t_dir_row dr(input t_mode m, input logic [7:0] x, input logic [7:0] y,
                                    input logic [3:0] w, input logic [3:0] h, input logic vis,
                                    input logic mir, input logic [7:0] extra,
                                    input logic [7:0] tile, input logic [7:0] pal);
        t_dir_row r;
        r.item  = '{m, x, y, w, h, vis, mir, extra, tile, pal};
        r.typed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    task automatic send_item(input t_sprite_item it, output int n);
        int gap;
        gap = 0;
        while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct && gap < 30) begin
            gap++;
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        in_mode     <= it.mode;
        in_sprite_x <= it.sprite_x;
        in_sprite_y <= it.sprite_y;
        in_width    <= it.width_tiles;
        in_height   <= it.height_tiles;
        in_visible  <= it.visible;
        in_mirrored <= it.mirrored;
        in_extra    <= it.extra_attr;
        in_tile     <= it.tile_index;
        in_palette  <= it.palette_attr;
        do @(posedge clk); while (!o_ready);
        n = expand_item(it);
        items_sent++;
    endtask

    task automatic drain_writes();
        in_valid <= 1'b0;
        while (expected_writes.size() != 0) @(posedge clk);
    endtask

    task automatic write_blank_tile(input logic [7:0] code);
        drain_writes();
        repeat (CFG_SETTLE) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= code;
        do @(posedge clk); while (!o_cfg_ready);
        blank_tile = code;
        cfg_writes++;
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int target);
        t_sprite_item it;
        int           n;
        int           start;
        int           nspr;
        int           ncells;
        start = items_sent;
        while (items_sent - start < target) begin
            if ($urandom_range(99) < 12) begin
                it = rand_item();
                send_item(it, n);
            end else begin
                it      = rand_item();
                it.mode = MODE_FRAME_START;
                send_item(it, n);
                nspr = $urandom_range(2, 1);
                repeat (nspr) begin
                    it      = rand_item();
                    it.mode = MODE_HEADER;
                    if ($urandom_range(9) != 0) begin
                        it.width_tiles  = 4'($urandom_range(4, 1));
                        it.height_tiles = 4'($urandom_range(3, 1));
                    end
                    it.visible = ($urandom_range(9) != 0);
                    ncells = it.width_tiles * it.height_tiles;
                    if (ncells > 12) begin
                        ncells = 12;
                    end
                    ncells += $urandom_range(1);
                    send_item(it, n);
                    repeat (ncells) begin
                        it      = rand_item();
                        it.mode = MODE_CELL;
                        if ($urandom_range(3) == 0) begin
                            it.tile_index = blank_tile;
                        end
                        send_item(it, n);
                    end
                end
                if ($urandom_range(9) < 8) begin
                    it      = rand_item();
                    it.mode = MODE_FRAME_END;
                    send_item(it, n);
                end
            end
        end
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                rx_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            rx_ready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge clk) begin : result_check
        t_slot_write want;
        if (rst_n && o_valid && rx_ready) begin
            if (expected_writes.size() == 0) begin
                flag_error($sformatf("slot write to slot %0d with none expected", o_slot));
            end else begin
                want = expected_writes.pop_front();
                check_field("slot", {2'b00, o_slot}, {2'b00, want.slot});
                check_field("tile_only", {7'd0, o_tile_only}, {7'd0, want.tile_only});
                check_field("tile_out", o_tile_out, want.tile);
                check_field("attr_out", o_attr_out, want.attr);
                check_field("screen_x", o_screen_x, want.x);
                check_field("screen_y", o_screen_y, want.y);
                check_field("last", {7'd0, o_last}, {7'd0, want.is_last});
                writes_checked++;
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && o_ready) || (o_valid && rx_ready) || (cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin : stimulus
        t_dir_row     r;
        t_sprite_item it;
        int           n;
        int           ph;
        int           tx_mix[4];
        int           rx_mix[4];
        logic [7:0]   codes[4];

        tx_mix = '{0, 66, 0, 35};
        rx_mix = '{0, 0, 66, 35};
        codes  = '{8'hFF, 8'h00, 8'h00, 8'h00};
        codes[1] = 8'($urandom);
        codes[3] = 8'($urandom);

        reset_predictor();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        dir_rows.push_back(dr(MODE_CELL,        8'h00, 8'h00, 4'd0,  4'd0,  1'b0, 1'b0, 8'h00,
                              8'h12, 8'h00));
        dir_rows.push_back(dr(MODE_FRAME_START, 8'hFF, 8'hFF, 4'd15, 4'd15, 1'b1, 1'b1, 8'hFF,
                              8'hFF, 8'hFF));
        dir_rows.push_back(dr(MODE_HEADER,      8'hFC, 8'hF8, 4'd2,  4'd2,  1'b1, 1'b0, 8'h80,
                              8'h00, 8'h00));
        r = dr(MODE_CELL, 8'h00, 8'h00, 4'd0, 4'd0, 1'b0, 1'b0, 8'h00, 8'hFF, 8'h01);
        r.typed = 1'b1;
        r.want  = '{6'd0, 1'b0, 8'hFF, 8'h81, 8'hFC, 8'hF8, 1'b1};
        dir_rows.push_back(r);
        dir_rows.push_back(dr(MODE_CELL,        8'h00, 8'h00, 4'd0,  4'd0,  1'b0, 1'b0, 8'h00,
                              8'h00, 8'h7F));
        dir_rows.push_back(dr(MODE_CELL,        8'h00, 8'h00, 4'd0,  4'd0,  1'b0, 1'b0, 8'h00,
                              8'h01, 8'hFE));
        dir_rows.push_back(dr(MODE_CELL,        8'h00, 8'h00, 4'd0,  4'd0,  1'b0, 1'b0, 8'h00,
                              8'h7F, 8'h00));
        dir_rows.push_back(dr(MODE_CELL,        8'h00, 8'h00, 4'd0,  4'd0,  1'b0, 1'b0, 8'h00,
                              8'h66, 8'h00));
        dir_rows.push_back(dr(MODE_HEADER,      8'h10, 8'h00, 4'd3,  4'd1,  1'b1, 1'b1, 8'h00,
                              8'h00, 8'h00));
        r = dr(MODE_CELL, 8'h00, 8'h00, 4'd0, 4'd0, 1'b0, 1'b0, 8'h00, 8'h55, 8'h0F);
        r.typed = 1'b1;
        r.want  = '{6'd3, 1'b0, 8'h55, 8'h2F, 8'h20, 8'h00, 1'b1};
        dir_rows.push_back(r);
        dir_rows.push_back(dr(MODE_CELL,        8'h00, 8'h00, 4'd0,  4'd0,  1'b0, 1'b0, 8'h00,
                              8'hAA, 8'hC0));
        dir_rows.push_back(dr(MODE_CELL,        8'h00, 8'h00, 4'd0,  4'd0,  1'b0, 1'b0, 8'h00,
                              8'h33, 8'h00));
        dir_rows.push_back(dr(MODE_HEADER,      8'hFF, 8'hFF, 4'd15, 4'd15, 1'b0, 1'b1, 8'hFF,
                              8'h00, 8'h00));
        dir_rows.push_back(dr(MODE_CELL,        8'h00, 8'h00, 4'd0,  4'd0,  1'b0, 1'b0, 8'h00,
                              8'h44, 8'h00));
        dir_rows.push_back(dr(MODE_HEADER,      8'h40, 8'h40, 4'd0,  4'd5,  1'b1, 1'b1, 8'h00,
                              8'h00, 8'h00));
        dir_rows.push_back(dr(MODE_CELL,        8'h00, 8'h00, 4'd0,  4'd0,  1'b0, 1'b0, 8'h00,
                              8'h45, 8'h00));
        dir_rows.push_back(dr(MODE_HEADER,      8'h00, 8'h00, 4'd15, 4'd15, 1'b1, 1'b1, 8'h00,
                              8'h00, 8'h00));
        r = dr(MODE_CELL, 8'h00, 8'h00, 4'd0, 4'd0, 1'b0, 1'b0, 8'h00, 8'h80, 8'h00);
        r.typed = 1'b1;
        r.want  = '{6'd6, 1'b0, 8'h80, 8'h20, 8'h70, 8'h00, 1'b1};
        dir_rows.push_back(r);
        dir_rows.push_back(dr(MODE_FRAME_END,   8'h00, 8'h00, 4'd0,  4'd0,  1'b0, 1'b0, 8'h00,
                              8'h00, 8'h00));
        dir_rows.push_back(dr(MODE_CELL,        8'h00, 8'h00, 4'd0,  4'd0,  1'b0, 1'b0, 8'h00,
                              8'h99, 8'h00));
        dir_rows.push_back(dr(MODE_HEADER,      8'h20, 8'h20, 4'd2,  4'd2,  1'b1, 1'b0, 8'h00,
                              8'h00, 8'h00));
        dir_rows.push_back(dr(MODE_FRAME_END,   8'h00, 8'h00, 4'd0,  4'd0,  1'b0, 1'b0, 8'h00,
                              8'h00, 8'h00));
        dir_rows.push_back(dr(MODE_FRAME_START, 8'h00, 8'h00, 4'd0,  4'd0,  1'b0, 1'b0, 8'h00,
                              8'h00, 8'h00));
        dir_rows.push_back(dr(MODE_FRAME_END,   8'h00, 8'h00, 4'd0,  4'd0,  1'b0, 1'b0, 8'h00,
                              8'h00, 8'h00));
        dir_rows.push_back(dr(MODE_FRAME_START, 8'h00, 8'h00, 4'd0,  4'd0,  1'b0, 1'b0, 8'h00,
                              8'h00, 8'h00));

        write_blank_tile(8'h00);
        foreach (dir_rows[i]) begin
            send_item(dir_rows[i].item, n);
            if (dir_rows[i].typed) begin
                if (n != 1) begin
                    flag_error($sformatf("directed row %0d: predictor gave %0d writes", i, n));
                end else begin
                    void'(expected_writes.pop_back());
                    expected_writes.push_back(dir_rows[i].want);
                end
            end
        end

        for (ph = 0; ph < 4; ph++) begin
            write_blank_tile(codes[ph]);
            tx_idle_pct  = tx_mix[ph];
            rx_stall_pct = rx_mix[ph];
            if (ph == 2) begin
                // hold the output off while a sprite overflows the slot table
                hold_req = 1'b1;
                it      = rand_item();
                it.mode = MODE_FRAME_START;
                send_item(it, n);
                it              = rand_item();
                it.mode         = MODE_HEADER;
                it.width_tiles  = 4'd7;
                it.height_tiles = 4'd6;
                it.visible      = 1'b1;
                send_item(it, n);
                repeat (42) begin
                    it            = rand_item();
                    it.mode       = MODE_CELL;
                    it.tile_index = blank_tile ^ 8'($urandom_range(255, 1));
                    send_item(it, n);
                end
                it      = rand_item();
                it.mode = MODE_FRAME_END;
                send_item(it, n);
            end
            run_random(4);
        end

        drain_writes();
        repeat (20) @(posedge clk);

        $display("Summary: %0d items, %0d slot writes checked, %0d register writes",
                 items_sent, writes_checked, cfg_writes);
        $display("Covered corner rows, four idle/stall mixes, a long hold-off and slot overflow");
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
